// ===== rtl/core/ts_packet_pid_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the transport stream PID filter core
// Implication checks on the rising clock edge, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef TS_PACKET_PID_FILTER_CORE_MACROS_SVH
`define TS_PACKET_PID_FILTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tspf_pkg.sv =====
// ----------------------------------------------------------------------------
// tspf_pkg
// Shared constants, codes and types of the transport stream PID filter.
// ----------------------------------------------------------------------------
package tspf_pkg;

	// Defaults of the top-level parameters.
	localparam int RECORDING_SLOTS_DEF = 4;
	localparam int PACKET_BYTES_DEF    = 188;

	// Fixed field widths.
	localparam int MAX_SLOTS   = 4;
	localparam int SLOT_PID_W  = 16;
	localparam int PID_W       = 13;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int VERDICT_W   = 3;

	typedef logic [SLOT_PID_W-1:0] slot_pid_t;
	typedef logic [VERDICT_W-1:0]  verdict_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	// Register indexes of the configuration channel.
	localparam cfg_index_t CFG_VIDEO_PIDS   = 3'd0;
	localparam cfg_index_t CFG_AUDIO_PIDS   = 3'd1;
	localparam cfg_index_t CFG_SERVICE_PIDS = 3'd2;
	localparam cfg_index_t CFG_PROGRAM_PIDS = 3'd3;
	localparam cfg_index_t CFG_REC_ENABLE   = 3'd4;

	// Verdict codes.
	localparam verdict_t VERDICT_ACCEPT    = 3'd0;
	localparam verdict_t VERDICT_BAD_SYNC  = 3'd1;
	localparam verdict_t VERDICT_TEI       = 3'd2;
	localparam verdict_t VERDICT_SCRAMBLED = 3'd3;
	localparam verdict_t VERDICT_AFC_RSVD  = 3'd4;

	// Header constants.
	localparam logic [7:0] SYNC_BYTE     = 8'h47;
	localparam logic [7:0] PID_HIGH_MASK = 8'h1f;
	localparam logic [7:0] TEI_MASK      = 8'h80;
	localparam logic [7:0] SCRAMBLE_MASK = 8'hc0;
	localparam logic [7:0] AFC_MASK      = 8'h30;

	// Header snapshot handed from the parser to the decision stage.
	typedef struct packed {
		logic       emit;     // item in the input register yields a decision
		logic       sync_ok;  // byte 0 of the open packet was the sync byte
		logic [7:0] hdr_one;
		logic [7:0] hdr_two;
		logic [7:0] hdr_three;
	} hdr_info_t;

endpackage

// ===== rtl/core/tspf_cfg.sv =====
// ----------------------------------------------------------------------------
// tspf_cfg
// Configuration register file: per-slot PIDs and the recording enables.
// ----------------------------------------------------------------------------
module tspf_cfg #(
	parameter int RECORDING_SLOTS = tspf_pkg::RECORDING_SLOTS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  tspf_pkg::cfg_index_t                      cfg_index,
	input  logic [tspf_pkg::CFG_DATA_W-1:0]           cfg_data,
	output tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] video_q,
	output tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] audio_q,
	output tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] service_q,
	output tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] program_q,
	output logic [RECORDING_SLOTS-1:0]                enable_q
);

	logic wr;

	// Registers are plain flops, so every request is taken at once.
	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_q   <= '0;
			audio_q   <= '0;
			service_q <= '0;
			program_q <= '0;
			enable_q  <= '0;
		end else if (wr) begin
			case (cfg_index)
				tspf_pkg::CFG_VIDEO_PIDS: begin
					video_q <= cfg_data[RECORDING_SLOTS*tspf_pkg::SLOT_PID_W-1:0];
				end
				tspf_pkg::CFG_AUDIO_PIDS: begin
					audio_q <= cfg_data[RECORDING_SLOTS*tspf_pkg::SLOT_PID_W-1:0];
				end
				tspf_pkg::CFG_SERVICE_PIDS: begin
					service_q <= cfg_data[RECORDING_SLOTS*tspf_pkg::SLOT_PID_W-1:0];
				end
				tspf_pkg::CFG_PROGRAM_PIDS: begin
					program_q <= cfg_data[RECORDING_SLOTS*tspf_pkg::SLOT_PID_W-1:0];
				end
				tspf_pkg::CFG_REC_ENABLE: begin
					enable_q <= cfg_data[RECORDING_SLOTS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/tspf_parse.sv =====
// ----------------------------------------------------------------------------
// tspf_parse
// Input register and packet position tracking; holds header bytes 1 and 2.
// ----------------------------------------------------------------------------
`include "ts_packet_pid_filter_core_macros.svh"

module tspf_parse #(
	parameter int PACKET_BYTES = tspf_pkg::PACKET_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_start,
	input  logic                take,
	output tspf_pkg::hdr_info_t hdr
);

	localparam int POS_W = $clog2(PACKET_BYTES);

	localparam logic [POS_W:0] POS_HDR_ONE   = (POS_W+1)'(1);
	localparam logic [POS_W:0] POS_HDR_TWO   = (POS_W+1)'(2);
	localparam logic [POS_W:0] POS_HDR_THREE = (POS_W+1)'(3);
	localparam logic [POS_W:0] POS_END       = (POS_W+1)'(PACKET_BYTES);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic [POS_W-1:0] pos_q;
	logic             in_pkt_q;
	logic             sync_q;
	logic [7:0]       hdr_one_q;
	logic [7:0]       hdr_two_q;
	logic [POS_W:0]   nxt;
	logic             adv;

	assign nxt = {1'b0, pos_q} + (POS_W+1)'(1);

	always_comb begin
		hdr.emit      = valid_s1 & ~start_s1 & in_pkt_q & (nxt == POS_HDR_THREE);
		hdr.sync_ok   = sync_q;
		hdr.hdr_one   = hdr_one_q;
		hdr.hdr_two   = hdr_two_q;
		hdr.hdr_three = byte_s1;
	end

	// A byte leaves the input register unless its decision finds the
	// result register still occupied.
	assign adv      = valid_s1 & (~hdr.emit | take);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= in_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			in_pkt_q  <= 1'b0;
			sync_q    <= 1'b0;
			hdr_one_q <= '0;
			hdr_two_q <= '0;
		end else if (adv) begin
			if (start_s1) begin
				pos_q    <= '0;
				in_pkt_q <= 1'b1;
				sync_q   <= (byte_s1 == tspf_pkg::SYNC_BYTE);
			end else if (in_pkt_q) begin
				if (nxt >= POS_END) begin
					in_pkt_q <= 1'b0;
					pos_q    <= '0;
				end else begin
					pos_q <= nxt[POS_W-1:0];
					if (nxt == POS_HDR_ONE) begin
						hdr_one_q <= byte_s1;
					end
					if (nxt == POS_HDR_TWO) begin
						hdr_two_q <= byte_s1;
					end
				end
			end
		end
	end

	`TSPF_ASSERT_SAME(a_emit_in_packet, clk, arst_n, hdr.emit, in_pkt_q && valid_s1,
		"decision raised outside an open packet")
	`TSPF_ASSERT_NEXT(a_closed_pos_zero, clk, arst_n, !in_pkt_q, in_pkt_q || pos_q == '0,
		"position not cleared while no packet is open")

endmodule

// ===== rtl/core/tspf_match.sv =====
// ----------------------------------------------------------------------------
// tspf_match
// Header checks, PID compare against every slot, and the result register.
// ----------------------------------------------------------------------------
`include "ts_packet_pid_filter_core_macros.svh"

module tspf_match #(
	parameter int RECORDING_SLOTS = tspf_pkg::RECORDING_SLOTS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  tspf_pkg::hdr_info_t                       hdr,
	output logic                                      take,
	input  tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] video,
	input  tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] audio,
	input  tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] service,
	input  tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] program_map,
	input  logic [RECORDING_SLOTS-1:0]                enable,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [tspf_pkg::MAX_SLOTS-1:0]            out_mask,
	output tspf_pkg::verdict_t                        out_verdict,
	output logic [tspf_pkg::PID_W-1:0]                out_pid
);

	logic [tspf_pkg::PID_W-1:0]      pid;
	tspf_pkg::slot_pid_t             pid_wide;
	tspf_pkg::verdict_t              verdict;
	logic [RECORDING_SLOTS-1:0]      hit;
	logic [tspf_pkg::MAX_SLOTS-1:0]  mask;
	logic                            out_valid_q;
	logic [tspf_pkg::MAX_SLOTS-1:0]  mask_q;
	tspf_pkg::verdict_t              verdict_q;
	logic [tspf_pkg::PID_W-1:0]      pid_q;

	always_comb begin
		if (hdr.sync_ok) begin
			pid = {hdr.hdr_one[4:0] & tspf_pkg::PID_HIGH_MASK[4:0], hdr.hdr_two};
		end else begin
			pid = '0;
		end
		pid_wide = tspf_pkg::SLOT_PID_W'(pid);

		if (!hdr.sync_ok) begin
			verdict = tspf_pkg::VERDICT_BAD_SYNC;
		end else if ((hdr.hdr_one & tspf_pkg::TEI_MASK) != '0) begin
			verdict = tspf_pkg::VERDICT_TEI;
		end else if ((hdr.hdr_three & tspf_pkg::SCRAMBLE_MASK) != '0) begin
			verdict = tspf_pkg::VERDICT_SCRAMBLED;
		end else if ((hdr.hdr_three & tspf_pkg::AFC_MASK) == '0) begin
			verdict = tspf_pkg::VERDICT_AFC_RSVD;
		end else begin
			verdict = tspf_pkg::VERDICT_ACCEPT;
		end
	end

	// One comparator bank per slot; PID zero hits every enabled slot. A wide slot
	// PID never equals the 13-bit PID, as its zero-extended top bits stay clear.
	for (genvar s = 0; s < RECORDING_SLOTS; s++) begin : g_slot
		assign hit[s] = enable[s] & ((pid == '0) || (pid_wide == video[s]) ||
			(pid_wide == audio[s]) || (pid_wide == service[s]) ||
			(pid_wide == program_map[s]));
	end

	always_comb begin
		mask = '0;
		if (verdict == tspf_pkg::VERDICT_ACCEPT) begin
			mask[RECORDING_SLOTS-1:0] = hit;
		end
	end

	assign take = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= hdr.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && hdr.emit) begin
			mask_q    <= mask;
			verdict_q <= verdict;
			pid_q     <= pid;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_mask    = mask_q;
	assign out_verdict = verdict_q;
	assign out_pid     = pid_q;

	`TSPF_ASSERT_SAME(a_reject_no_mask, clk, arst_n,
		out_valid_q && verdict_q != tspf_pkg::VERDICT_ACCEPT, mask_q == '0,
		"rejected packet carries a write mask")
	`TSPF_ASSERT_SAME(a_bad_sync_pid, clk, arst_n,
		out_valid_q && verdict_q == tspf_pkg::VERDICT_BAD_SYNC, pid_q == '0,
		"bad sync packet carries a nonzero PID")
	`TSPF_ASSERT_NEXT(a_held_result, clk, arst_n, out_valid_q && !out_ready,
		out_valid_q && $stable(pid_q) && $stable(verdict_q),
		"stalled result was lost or altered")

endmodule

// ===== rtl/core/ts_packet_pid_filter_core.sv =====
// ----------------------------------------------------------------------------
// ts_packet_pid_filter_core
// Transport stream PID filter: one header decision per packet.
// ----------------------------------------------------------------------------
// Usage
// The slave stream carries one transport stream byte per request in
// s_axis_tdata, with s_axis_tuser set on the first byte of each packet. Bytes
// outside an open packet, and bytes after the last one of a packet, are
// absorbed without a result. On the fourth byte of a packet the master stream
// delivers one request: write mask, verdict and PID.
// The configuration channel writes the slot PID registers and the recording
// enables; it is always ready and should only be used while the stream idles.
// The accepted fourth byte sits in the input register while the header checks
// and the PID compare of all slots run in one pass into the result register,
// which drives m_axis_tvalid. One byte is taken every cycle. When the receiver
// stalls, the finished result waits in the result register and bytes that
// yield no result still flow; only a second decision waits in the input
// register, and s_axis_tready falls until the result goes.
// Reset clears the packet tracking, the held header bytes, both valid flags
// and all configuration registers; no packet is open after reset.
// ----------------------------------------------------------------------------
module ts_packet_pid_filter_core #(
	parameter int RECORDING_SLOTS = tspf_pkg::RECORDING_SLOTS_DEF,
	parameter int PACKET_BYTES    = tspf_pkg::PACKET_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]                      s_axis_tuser,  // [0] packet_start
	// Result stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [3:0] write_mask, [6:4] verdict, [19:7] packet_id, [23:20] zero
	output logic [23:0]                     m_axis_tdata,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  tspf_pkg::cfg_index_t            cfg_index,
	input  logic [tspf_pkg::CFG_DATA_W-1:0] cfg_data
);

	tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] video_q;
	tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] audio_q;
	tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] service_q;
	tspf_pkg::slot_pid_t [RECORDING_SLOTS-1:0] program_q;
	logic [RECORDING_SLOTS-1:0]                enable_q;
	tspf_pkg::hdr_info_t                       hdr;
	logic                                      take;
	logic [tspf_pkg::MAX_SLOTS-1:0]            res_mask;
	tspf_pkg::verdict_t                        res_verdict;
	logic [tspf_pkg::PID_W-1:0]                res_pid;

	// Register file written over the configuration channel.
	tspf_cfg #(
		.RECORDING_SLOTS(RECORDING_SLOTS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.video_q   (video_q),
		.audio_q   (audio_q),
		.service_q (service_q),
		.program_q (program_q),
		.enable_q  (enable_q)
	);

	// Input register and packet tracking.
	tspf_parse #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_start (s_axis_tuser[0]),
		.take     (take),
		.hdr      (hdr)
	);

	// Header checks, slot matching and the result register.
	tspf_match #(
		.RECORDING_SLOTS(RECORDING_SLOTS)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.hdr         (hdr),
		.take        (take),
		.video       (video_q),
		.audio       (audio_q),
		.service     (service_q),
		.program_map (program_q),
		.enable      (enable_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_mask    (res_mask),
		.out_verdict (res_verdict),
		.out_pid     (res_pid)
	);

	assign m_axis_tdata = {4'b0000, res_pid, res_verdict, res_mask};

endmodule
